// File: rtl/rdi_pkg.sv
// Shared constants and types for the ray/disk intersection block.
// No dependencies; every module imports this package, the interfaces do not.
package rdi_pkg;

	// Default coordinate format: signed Q16.16 in 32 bits
	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;

	// Reset value of the min_distance register, raw Q16.16
	localparam int MIN_DISTANCE_RESET = 66;

	// Depth of the queue between classification and the back end
	localparam int QUEUE_DEPTH = 4;

	// Register indexes on the configuration port
	localparam logic [2:0] REG_CENTER_X     = 3'd0;
	localparam logic [2:0] REG_CENTER_Y     = 3'd1;
	localparam logic [2:0] REG_CENTER_Z     = 3'd2;
	localparam logic [2:0] REG_NORMAL_X     = 3'd3;
	localparam logic [2:0] REG_NORMAL_Y     = 3'd4;
	localparam logic [2:0] REG_NORMAL_Z     = 3'd5;
	localparam logic [2:0] REG_DISK_RADIUS  = 3'd6;
	localparam logic [2:0] REG_MIN_DISTANCE = 3'd7;

	// Classification of one ray, formed in the front end
	typedef struct packed {
		logic den_zero;
		logic neg;
	} rdi_cls_t;

endpackage

// File: rtl/rdi_if.sv
// Valid/ready channel interfaces for rays in and intersection results out.
// Depends on nothing; widths follow the COORD_WIDTH parameter.
interface rdi_ray_if #(parameter int COORD_WIDTH = 32) ();
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] origin_x;
	logic signed [COORD_WIDTH-1:0] origin_y;
	logic signed [COORD_WIDTH-1:0] origin_z;
	logic signed [COORD_WIDTH-1:0] direction_x;
	logic signed [COORD_WIDTH-1:0] direction_y;
	logic signed [COORD_WIDTH-1:0] direction_z;

	modport source (output valid, origin_x, origin_y, origin_z,
		direction_x, direction_y, direction_z, input ready);
	modport sink (input valid, origin_x, origin_y, origin_z,
		direction_x, direction_y, direction_z, output ready);
endinterface

interface rdi_hit_if #(parameter int COORD_WIDTH = 32) ();
	logic                          valid;
	logic                          ready;
	logic                          is_hit;
	logic signed [COORD_WIDTH-1:0] hit_distance;
	logic signed [COORD_WIDTH-1:0] hit_point_x;
	logic signed [COORD_WIDTH-1:0] hit_point_y;
	logic signed [COORD_WIDTH-1:0] hit_point_z;

	modport source (output valid, is_hit, hit_distance, hit_point_x, hit_point_y,
		hit_point_z, input ready);
	modport sink (input valid, is_hit, hit_distance, hit_point_x, hit_point_y,
		hit_point_z, output ready);
endinterface

// File: rtl/ray_disk_intersect.sv
// Ray/disk intersection: accepts one ray per cycle unless back-pressure from the result
// channel holds it, and returns one result per ray. Coordinates default to signed Q16.16.
// It has three front stages, the queue, a numerator scaling stage, a divider with one stage
// per quotient bit (COORD_WIDTH + 1) and five finishing stages.
// The pipelined divider sets the latency.
// Reset clears all valid bits and the queue and loads the register reset values.
// Depends on rdi_pkg, rdi_if, rdi_front, rdi_queue and rdi_back.
module ray_disk_intersect import rdi_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	localparam int PDW        = (COORD_WIDTH > 32) ? 64 : 32,
	localparam int PAW        = (COORD_WIDTH > 32) ? 6 : 5
) (
	input  logic           clk,
	input  logic           arst_n,
	rdi_ray_if.sink        ray,
	rdi_hit_if.source      hit,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [PAW-1:0] paddr,
	input  logic [PDW-1:0] pwdata,
	output logic [PDW-1:0] prdata,
	output logic           pready
);
	localparam int NRW = FRAC_BITS + 2;
	localparam int SW  = COORD_WIDTH + FRAC_BITS + 5;
	localparam int QW  = 2 * SW + 6 * COORD_WIDTH + 2;

	// Configuration registers
	logic signed [COORD_WIDTH-1:0] center_q [3];
	logic signed [NRW-1:0]         normal_q [3];
	logic [COORD_WIDTH-2:0]        radius_q, min_dist_q;
	logic [2:0]                    reg_idx;
	logic                          wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PAW-1:PAW-3];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q[0] <= '0;
			center_q[1] <= '0;
			center_q[2] <= '0;
			normal_q[0] <= '0;
			normal_q[1] <= {2'b01, {FRAC_BITS{1'b0}}};
			normal_q[2] <= '0;
			radius_q    <= '0;
			min_dist_q  <= (COORD_WIDTH-1)'(MIN_DISTANCE_RESET);
		end else if (wr_en) begin
			case (reg_idx)
				REG_CENTER_X:     center_q[0] <= pwdata[COORD_WIDTH-1:0];
				REG_CENTER_Y:     center_q[1] <= pwdata[COORD_WIDTH-1:0];
				REG_CENTER_Z:     center_q[2] <= pwdata[COORD_WIDTH-1:0];
				REG_NORMAL_X:     normal_q[0] <= pwdata[NRW-1:0];
				REG_NORMAL_Y:     normal_q[1] <= pwdata[NRW-1:0];
				REG_NORMAL_Z:     normal_q[2] <= pwdata[NRW-1:0];
				REG_DISK_RADIUS:  radius_q    <= pwdata[COORD_WIDTH-2:0];
				REG_MIN_DISTANCE: min_dist_q  <= pwdata[COORD_WIDTH-2:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (reg_idx)
			REG_CENTER_X:     prdata = PDW'(unsigned'(center_q[0]));
			REG_CENTER_Y:     prdata = PDW'(unsigned'(center_q[1]));
			REG_CENTER_Z:     prdata = PDW'(unsigned'(center_q[2]));
			REG_NORMAL_X:     prdata = PDW'(unsigned'(normal_q[0]));
			REG_NORMAL_Y:     prdata = PDW'(unsigned'(normal_q[1]));
			REG_NORMAL_Z:     prdata = PDW'(unsigned'(normal_q[2]));
			REG_DISK_RADIUS:  prdata = PDW'(radius_q);
			REG_MIN_DISTANCE: prdata = PDW'(min_dist_q);
			default:          prdata = '0;
		endcase
	end

	// Front end
	logic signed [COORD_WIDTH-1:0] ray_org [3], ray_dir [3];
	logic                          f_valid, f_ready;
	logic [SW-1:0]                 f_num, f_den;
	rdi_cls_t                      f_cls;
	logic signed [COORD_WIDTH-1:0] f_org [3], f_dir [3];

	assign ray_org[0] = ray.origin_x;
	assign ray_org[1] = ray.origin_y;
	assign ray_org[2] = ray.origin_z;
	assign ray_dir[0] = ray.direction_x;
	assign ray_dir[1] = ray.direction_y;
	assign ray_dir[2] = ray.direction_z;

	rdi_front #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ray.valid),
		.in_ready  (ray.ready),
		.in_org    (ray_org),
		.in_dir    (ray_dir),
		.center    (center_q),
		.normal    (normal_q),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_num   (f_num),
		.out_den   (f_den),
		.out_cls   (f_cls),
		.out_org   (f_org),
		.out_dir   (f_dir)
	);

	// Queue between front and back
	logic [QW-1:0] q_in, q_out;
	logic          b_valid, b_ready;

	assign q_in = {f_num, f_den, f_cls, f_org[0], f_org[1], f_org[2],
		f_dir[0], f_dir[1], f_dir[2]};

	rdi_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (q_in),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (q_out)
	);

	logic [SW-1:0]                 b_num, b_den;
	rdi_cls_t                      b_cls;
	logic signed [COORD_WIDTH-1:0] b_org [3], b_dir [3];

	assign {b_num, b_den, b_cls, b_org[0], b_org[1], b_org[2],
		b_dir[0], b_dir[1], b_dir[2]} = q_out;

	// Back end
	logic signed [COORD_WIDTH-1:0] b_point [3];

	rdi_back #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (b_valid),
		.in_ready  (b_ready),
		.in_num    (b_num),
		.in_den    (b_den),
		.in_cls    (b_cls),
		.in_org    (b_org),
		.in_dir    (b_dir),
		.center    (center_q),
		.radius    (radius_q),
		.min_dist  (min_dist_q),
		.out_valid (hit.valid),
		.out_ready (hit.ready),
		.out_hit   (hit.is_hit),
		.out_dist  (hit.hit_distance),
		.out_point (b_point)
	);

	assign hit.hit_point_x = b_point[0];
	assign hit.hit_point_y = b_point[1];
	assign hit.hit_point_z = b_point[2];

endmodule

// File: rtl/rdi_front.sv
// Front end: forms the plane numerator and denominator and classifies the ray.
// Depends on rdi_pkg (rdi_cls_t).
module rdi_front import rdi_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	localparam int SW         = COORD_WIDTH + FRAC_BITS + 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] in_org [3],
	input  logic signed [COORD_WIDTH-1:0] in_dir [3],
	input  logic signed [COORD_WIDTH-1:0] center [3],
	input  logic signed [FRAC_BITS+1:0]   normal [3],
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic        [SW-1:0]          out_num,
	output logic        [SW-1:0]          out_den,
	output rdi_cls_t                      out_cls,
	output logic signed [COORD_WIDTH-1:0] out_org [3],
	output logic signed [COORD_WIDTH-1:0] out_dir [3]
);
	localparam int NRW = FRAC_BITS + 2;
	localparam int DW  = COORD_WIDTH + 1;
	localparam int NPW = DW + NRW;
	localparam int DPW = COORD_WIDTH + NRW;

	logic                          valid_s1, valid_s2, valid_s3;
	logic                          adv1, adv2, adv3;
	logic signed [DW-1:0]          diff_s1 [3];
	logic signed [COORD_WIDTH-1:0] org_s1 [3], org_s2 [3], org_s3 [3];
	logic signed [COORD_WIDTH-1:0] dir_s1 [3], dir_s2 [3], dir_s3 [3];
	logic signed [NPW-1:0]         nprod_s2 [3];
	logic signed [DPW-1:0]         dprod_s2 [3];
	logic signed [SW-1:0]          num_s3, den_s3;
	logic signed [SW-1:0]          num_sum, den_sum;

	// Advance each stage when the next one can take its contents
	assign adv3     = !valid_s3 || out_ready;
	assign adv2     = !valid_s2 || adv3;
	assign adv1     = !valid_s1 || adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= in_valid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
		end
	end

	// Stage 1: center minus origin
	always_ff @(posedge clk) begin
		if (adv1) begin
			for (int i = 0; i < 3; i++) begin
				diff_s1[i] <= DW'(center[i]) - DW'(in_org[i]);
				org_s1[i]  <= in_org[i];
				dir_s1[i]  <= in_dir[i];
			end
		end
	end

	// Stage 2: per-axis products with the normal
	always_ff @(posedge clk) begin
		if (adv2) begin
			for (int i = 0; i < 3; i++) begin
				nprod_s2[i] <= diff_s1[i] * NPW'(normal[i]);
				dprod_s2[i] <= dir_s1[i] * DPW'(normal[i]);
				org_s2[i]   <= org_s1[i];
				dir_s2[i]   <= dir_s1[i];
			end
		end
	end

	// Stage 3: dot products
	assign num_sum = SW'(nprod_s2[0]) + SW'(nprod_s2[1]) + SW'(nprod_s2[2]);
	assign den_sum = SW'(dprod_s2[0]) + SW'(dprod_s2[1]) + SW'(dprod_s2[2]);

	always_ff @(posedge clk) begin
		if (adv3) begin
			num_s3 <= num_sum;
			den_s3 <= den_sum;
			org_s3 <= org_s2;
			dir_s3 <= dir_s2;
		end
	end

	// Classify: magnitudes, quotient sign, parallel ray
	assign out_valid        = valid_s3;
	assign out_num          = num_s3[SW-1] ? SW'(-num_s3) : SW'(num_s3);
	assign out_den          = den_s3[SW-1] ? SW'(-den_s3) : SW'(den_s3);
	assign out_cls.neg      = num_s3[SW-1] ^ den_s3[SW-1];
	assign out_cls.den_zero = (den_s3 == '0);
	assign out_org          = org_s3;
	assign out_dir          = dir_s3;

endmodule

// File: rtl/rdi_queue.sv
// Short transaction queue between the front end and the back end.
// Depends on rdi_pkg for the default depth.
module rdi_queue import rdi_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    count_q;
	logic             push, pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem[rd_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) mem[wr_q] <= push_data;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)  rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

// File: rtl/rdi_back.sv
// Back end: pipelined divider for t, hit point, radius test and result register.
// Depends on rdi_pkg (rdi_cls_t).
module rdi_back import rdi_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	localparam int SW         = COORD_WIDTH + FRAC_BITS + 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic        [SW-1:0]          in_num,
	input  logic        [SW-1:0]          in_den,
	input  rdi_cls_t                      in_cls,
	input  logic signed [COORD_WIDTH-1:0] in_org [3],
	input  logic signed [COORD_WIDTH-1:0] in_dir [3],
	input  logic signed [COORD_WIDTH-1:0] center [3],
	input  logic        [COORD_WIDTH-2:0] radius,
	input  logic        [COORD_WIDTH-2:0] min_dist,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          out_hit,
	output logic signed [COORD_WIDTH-1:0] out_dist,
	output logic signed [COORD_WIDTH-1:0] out_point [3]
);
	localparam int CWD = COORD_WIDTH;
	localparam int QB  = CWD + 1;
	localparam int NW  = SW + FRAC_BITS;
	localparam int WW  = SW + QB + FRAC_BITS;
	localparam int PRW = 2 * CWD;
	localparam int EW  = 2 * CWD + 1;
	localparam int DSW = 2 * CWD + 2;

	localparam logic [QB-1:0]        LIM_Q   = QB'((64'd1 << (CWD - 1)) - 64'd1);
	localparam logic signed [EW-1:0] LIM_E   = EW'(LIM_Q);
	localparam logic signed [CWD-1:0] T_MAX  = {1'b0, {(CWD-1){1'b1}}};
	localparam logic signed [CWD-1:0] T_MIN  = {1'b1, {(CWD-1){1'b0}}};

	logic en;

	// Divider pipeline, one quotient bit per stage
	logic                  vld_s [QB+1];
	logic [WW-1:0]         rem_s [QB+1];
	logic [SW-1:0]         den_s [QB+1];
	logic [QB-1:0]         quo_s [QB+1];
	logic                  ovf_s [QB+1];
	rdi_cls_t              cls_s [QB+1];
	logic signed [CWD-1:0] org_s [QB+1][3];
	logic signed [CWD-1:0] dir_s [QB+1][3];

	// Finishing stages
	logic                  v_s1, v_s2, v_s3, v_s4, out_valid_q;
	logic signed [CWD-1:0] t_s1, t_s2, t_s3, t_s4;
	logic                  miss_s1, miss_s2, miss_s3, miss_s4;
	logic signed [CWD-1:0] org_s1 [3], org_s2 [3], dir_s1 [3];
	logic signed [PRW-1:0] prod_s2 [3];
	logic signed [CWD-1:0] diff_s3 [3], diff_s4 [3];
	logic signed [PRW-1:0] sq_s4 [3];
	logic [PRW-1:0]        rr_s4;

	logic                  out_hit_q;
	logic signed [CWD-1:0] out_dist_q;
	logic signed [CWD-1:0] out_point_q [3];

	// The whole back end stalls together on the result register
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	// Stage 0: scale numerator, flag quotients that cannot fit
	logic [WW-1:0] num_full;
	assign num_full = {{(WW-NW){1'b0}}, in_num, {FRAC_BITS{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s[0] <= 1'b0;
		else if (en) vld_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num_full;
			den_s[0] <= in_den;
			quo_s[0] <= '0;
			ovf_s[0] <= (num_full >= (WW'(in_den) << QB));
			cls_s[0] <= in_cls;
			org_s[0] <= in_org;
			dir_s[0] <= in_dir;
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_div
		localparam int B = QB - 1 - k;
		logic [WW-1:0] dsh;
		logic          fits;

		assign dsh  = WW'(den_s[k]) << B;
		assign fits = (rem_s[k] >= dsh);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k+1] <= 1'b0;
			else if (en) vld_s[k+1] <= vld_s[k];
		end

		// Subtract the shifted divisor where it fits
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= fits ? rem_s[k] - dsh : rem_s[k];
				quo_s[k+1] <= quo_s[k] | (QB'(fits) << B);
				den_s[k+1] <= den_s[k];
				ovf_s[k+1] <= ovf_s[k];
				cls_s[k+1] <= cls_s[k];
				org_s[k+1] <= org_s[k];
				dir_s[k+1] <= dir_s[k];
			end
		end
	end

	// Stage 1: signed, saturated t
	logic [QB-1:0]         q_end;
	logic                  q_neg, q_big;
	logic signed [CWD-1:0] t_next;

	assign q_end = quo_s[QB];
	assign q_neg = cls_s[QB].neg;
	assign q_big = ovf_s[QB] || (q_neg ? (q_end > LIM_Q + 1'b1) : (q_end > LIM_Q));

	always_comb begin
		if (cls_s[QB].den_zero)
			t_next = '0;
		else if (q_big)
			t_next = q_neg ? T_MIN : T_MAX;
		else
			t_next = q_neg ? -$signed(q_end[CWD-1:0]) : $signed(q_end[CWD-1:0]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1    <= t_next;
			miss_s1 <= cls_s[QB].den_zero || q_big;
			org_s1  <= org_s[QB];
			dir_s1  <= dir_s[QB];
		end
	end

	// Stage 2: t times direction, near-distance reject
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				prod_s2[i] <= PRW'(t_s1) * PRW'(dir_s1[i]);
			miss_s2 <= miss_s1 || (t_s1 <= $signed({1'b0, min_dist}));
			t_s2    <= t_s1;
			org_s2  <= org_s1;
		end
	end

	// Stage 3: hit point relative to the center, far offsets count as a miss
	logic signed [EW-1:0] rel [3];
	logic                 far;

	always_comb begin
		far = 1'b0;
		for (int i = 0; i < 3; i++) begin
			rel[i] = EW'(prod_s2[i] >>> FRAC_BITS) + EW'(org_s2[i]) - EW'(center[i]);
			if (rel[i] > LIM_E || rel[i] < -LIM_E) far = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				diff_s3[i] <= rel[i][CWD-1:0];
			miss_s3 <= miss_s2 || far;
			t_s3    <= t_s2;
		end
	end

	// Stage 4: squares of the offset and of the radius
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				sq_s4[i] <= PRW'(diff_s3[i]) * PRW'(diff_s3[i]);
			rr_s4   <= PRW'(radius) * PRW'(radius);
			diff_s4 <= diff_s3;
			miss_s4 <= miss_s3;
			t_s4    <= t_s3;
		end
	end

	// Result: radius test and saturated hit point
	logic [DSW-1:0]        dist_sq;
	logic                  hit;
	logic signed [CWD:0]   psum [3];
	logic signed [CWD-1:0] pnt [3];

	assign dist_sq = DSW'(unsigned'(sq_s4[0])) + DSW'(unsigned'(sq_s4[1]))
		+ DSW'(unsigned'(sq_s4[2]));
	assign hit     = !miss_s4 && (dist_sq < DSW'(rr_s4));

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			psum[i] = (CWD+1)'(center[i]) + (CWD+1)'(diff_s4[i]);
			if (psum[i][CWD] != psum[i][CWD-1])
				pnt[i] = psum[i][CWD] ? T_MIN : T_MAX;
			else
				pnt[i] = psum[i][CWD-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_hit_q  <= hit;
			out_dist_q <= t_s4;
			for (int i = 0; i < 3; i++)
				out_point_q[i] <= hit ? pnt[i] : '0;
		end
	end

	// Valid bits of the finishing stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= vld_s[QB];
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	assign out_valid = out_valid_q;
	assign out_hit   = out_hit_q;
	assign out_dist  = out_dist_q;
	assign out_point = out_point_q;

endmodule

// File: test/ray_disk_intersect_chk.sv
// Checker for ray_disk_intersect: mirrors register writes, predicts each result
// and compares it with the result channel. Depends on rdi_pkg and rdi_if.
module ray_disk_intersect_chk import rdi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	rdi_ray_if          ray,
	rdi_hit_if          hit,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output int          fails,
	output int          pending
);

	typedef struct packed {
		logic               is_hit;
		logic signed [31:0] t_dist;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
	} hit_rec_t;

	localparam logic signed [127:0] LIM = 128'sd2147483647;

	logic signed [31:0] ctr_r [3];
	logic signed [17:0] nrm_r [3];
	logic [30:0]        radius_r;
	logic [30:0]        mind_r;
	hit_rec_t           expected_hits [$];

	// Intersection of one ray with the mirrored disk, exact wide arithmetic
	function automatic hit_rec_t calc_hit(logic signed [31:0] o [3], logic signed [31:0] dv [3]);
		logic signed [127:0] org [3], dir [3], ctr [3], nrm [3], dif [3];
		logic signed [127:0] num, den, an, ad, qs, tt, d, dsq, rr, p, mind, rad;
		logic [127:0]        q;
		logic                neg;
		hit_rec_t            h;
		h = '0;
		num = 0;
		den = 0;
		dsq = 0;
		for (int i = 0; i < 3; i++) begin
			org[i] = o[i];
			dir[i] = dv[i];
			ctr[i] = ctr_r[i];
			nrm[i] = nrm_r[i];
			num = num + (ctr[i] - org[i]) * nrm[i];
			den = den + dir[i] * nrm[i];
		end
		if (den == 0)
			return h;
		neg = num[127] != den[127];
		an = num < 0 ? -num : num;
		ad = den < 0 ? -den : den;
		q = ($unsigned(an) << 16) / $unsigned(ad);
		qs = $signed(q);
		if (qs > (neg ? LIM + 1 : LIM)) begin
			tt = neg ? -LIM - 1 : LIM;
			h.t_dist = tt[31:0];
			return h;
		end
		tt = neg ? -qs : qs;
		h.t_dist = tt[31:0];
		mind = {97'b0, mind_r};
		if (tt <= mind)
			return h;
		for (int i = 0; i < 3; i++) begin
			d = ((tt * dir[i]) >>> 16) + (org[i] - ctr[i]);
			if (d > LIM || d < -LIM)
				return h;
			dif[i] = d;
			dsq = dsq + d * d;
		end
		rad = {97'b0, radius_r};
		rr = rad * rad;
		if (!(dsq < rr))
			return h;
		h.is_hit = 1'b1;
		for (int i = 0; i < 3; i++) begin
			p = ctr[i] + dif[i];
			if (p > LIM)
				p = LIM;
			else if (p < -LIM - 1)
				p = -LIM - 1;
			if (i == 0)
				h.px = p[31:0];
			else if (i == 1)
				h.py = p[31:0];
			else
				h.pz = p[31:0];
		end
		return h;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
		fails++;
	endtask

	initial begin
		fails = 0;
		pending = 0;
	end

	// Track registers, queue predictions, compare results
	always @(posedge clk or negedge arst_n) begin
		logic signed [31:0] o [3], dv [3];
		hit_rec_t want;
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				ctr_r[i] = '0;
				nrm_r[i] = '0;
			end
			nrm_r[1] = 18'sd65536;
			radius_r = '0;
			mind_r = 31'(MIN_DISTANCE_RESET);
			expected_hits.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_CENTER_X:     ctr_r[0] = pwdata;
					REG_CENTER_Y:     ctr_r[1] = pwdata;
					REG_CENTER_Z:     ctr_r[2] = pwdata;
					REG_NORMAL_X:     nrm_r[0] = pwdata[17:0];
					REG_NORMAL_Y:     nrm_r[1] = pwdata[17:0];
					REG_NORMAL_Z:     nrm_r[2] = pwdata[17:0];
					REG_DISK_RADIUS:  radius_r = pwdata[30:0];
					REG_MIN_DISTANCE: mind_r = pwdata[30:0];
					default: ;
				endcase
			end
			if (ray.valid && ray.ready) begin
				o[0] = ray.origin_x;
				o[1] = ray.origin_y;
				o[2] = ray.origin_z;
				dv[0] = ray.direction_x;
				dv[1] = ray.direction_y;
				dv[2] = ray.direction_z;
				expected_hits.push_back(calc_hit(o, dv));
			end
			if (hit.valid && hit.ready) begin
				if (expected_hits.size() == 0) begin
					report("unexpected result", 32'(hit.is_hit), 32'h0);
				end else begin
					want = expected_hits.pop_front();
					if (hit.is_hit !== want.is_hit)
						report("is_hit", 32'(hit.is_hit), 32'(want.is_hit));
					if (hit.hit_distance !== want.t_dist)
						report("hit_distance", hit.hit_distance, want.t_dist);
					if (hit.hit_point_x !== want.px)
						report("hit_point_x", hit.hit_point_x, want.px);
					if (hit.hit_point_y !== want.py)
						report("hit_point_y", hit.hit_point_y, want.py);
					if (hit.hit_point_z !== want.pz)
						report("hit_point_z", hit.hit_point_z, want.pz);
				end
			end
		end
		pending = expected_hits.size();
	end

endmodule

// File: test/ray_disk_intersect_tb.sv
// Top of the ray_disk_intersect testbench: clock, reset, register writes, ray
// stimulus and verdict. Depends on rdi_pkg, rdi_if, ray_disk_intersect and ray_disk_intersect_chk.
module ray_disk_intersect_tb;
	import rdi_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN = 60;
	localparam longint ONE = 65536;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;
	int          fails, pending;
	int          idle_pct, stall_pct, quiet_cycles;
	longint      cx [3], nv [3], rad;

	rdi_ray_if ray ();
	rdi_hit_if hit ();

	ray_disk_intersect DUT (
		.clk, .arst_n, .ray(ray.sink), .hit(hit.source),
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	ray_disk_intersect_chk chk (
		.clk, .arst_n, .ray, .hit, .psel, .penable, .pwrite, .pready,
		.paddr, .pwdata, .fails, .pending
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Random stall on the result side
	always @(posedge clk)
		hit.ready <= ($urandom_range(99) >= stall_pct);

	// Watchdog: end the run when no transaction moves for too long
	always @(posedge clk) begin
		if ((ray.valid && ray.ready) || (hit.valid && hit.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("ray_disk_intersect test failed");
			$finish;
		end
	end

	// Setup cycle, then access cycle; the bus stays selected for the next write
	task automatic reg_write(logic [2:0] idx, longint value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value[31:0];
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
	endtask

	// Wait until the pipeline is empty, then load a whole disk setting
	task automatic set_disk(longint c0, longint c1, longint c2, longint n0, longint n1,
			longint n2, longint r, longint mind);
		ray.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		cx[0] = c0; cx[1] = c1; cx[2] = c2;
		nv[0] = n0; nv[1] = n1; nv[2] = n2;
		rad = r;
		reg_write(REG_CENTER_X, c0);
		reg_write(REG_CENTER_Y, c1);
		reg_write(REG_CENTER_Z, c2);
		reg_write(REG_NORMAL_X, n0);
		reg_write(REG_NORMAL_Y, n1);
		reg_write(REG_NORMAL_Z, n2);
		reg_write(REG_DISK_RADIUS, r);
		reg_write(REG_MIN_DISTANCE, mind);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Offer one ray, idling first at random, and hold it until accepted
	task automatic send_ray(longint ox, longint oy, longint oz, longint dx, longint dy,
			longint dz);
		while ($urandom_range(99) < idle_pct) begin
			ray.valid <= 1'b0;
			@(posedge clk);
		end
		ray.valid <= 1'b1;
		ray.origin_x <= ox[31:0];
		ray.origin_y <= oy[31:0];
		ray.origin_z <= oz[31:0];
		ray.direction_x <= dx[31:0];
		ray.direction_y <= dy[31:0];
		ray.direction_z <= dz[31:0];
		@(posedge clk);
		while (!ray.ready)
			@(posedge clk);
	endtask

	function automatic longint rnd32();
		return longint'($signed($urandom()));
	endfunction

	function automatic longint rnd_span(longint half);
		return longint'($urandom_range(0, 32'(2 * half))) - half;
	endfunction

	// Mostly rays aimed at the disk, the rest noise and degenerate rays
	task automatic random_ray();
		longint o [3], dv [3], k, t, span;
		int pick;
		pick = $urandom_range(99);
		if (pick < 70) begin
			k = longint'($urandom_range(1, 4)) * ONE;
			if ($urandom_range(1))
				k = -k;
			t = $urandom_range(1, 16 * 65536);
			span = rad > (1 << 24) ? (1 << 24) : rad;
			span = span * 5 / 8 + 1;
			for (int i = 0; i < 3; i++) begin
				dv[i] = ((nv[i] * k) >>> 16) + rnd_span(1000);
				o[i] = cx[i] + rnd_span(span) - ((t * dv[i]) >>> 16);
			end
		end else if (pick < 80) begin
			for (int i = 0; i < 3; i++) begin
				o[i] = rnd32();
				dv[i] = rnd32();
			end
		end else if (pick < 90) begin
			for (int i = 0; i < 3; i++) begin
				o[i] = rnd_span(ONE * 64);
				dv[i] = 0;
			end
		end else begin
			for (int i = 0; i < 3; i++) begin
				o[i] = rnd_span(ONE * 32);
				dv[i] = rnd_span(ONE * 4);
			end
		end
		send_ray(o[0], o[1], o[2], dv[0], dv[1], dv[2]);
	endtask

	task automatic random_phase(int n, int idle, int stall, bit hold);
		idle_pct = idle;
		stall_pct = stall;
		for (int i = 0; i < n; i++) begin
			if (hold && i == n / 2) begin
				ray.valid <= 1'b0;
				@(posedge clk);
				while (pending != 0)
					@(posedge clk);
			end
			random_ray();
		end
	endtask

	function automatic longint rnd_normal();
		return longint'($urandom_range(0, 131072)) - ONE;
	endfunction

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		ray.valid = 1'b0;
		ray.origin_x = '0;
		ray.origin_y = '0;
		ray.origin_z = '0;
		ray.direction_x = '0;
		ray.direction_y = '0;
		ray.direction_z = '0;
		hit.ready = 1'b0;
		quiet_cycles = 0;
		idle_pct = 0;
		stall_pct = 0;
		cx[0] = 0; cx[1] = 0; cx[2] = 0;
		nv[0] = 0; nv[1] = ONE; nv[2] = 0;
		rad = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset setting: a downward ray can never hit a zero-radius disk
		send_ray(0, 5 * ONE, 0, 0, -ONE, 0);
		send_ray(0, 67, 0, 0, -ONE, 0);

		// Directed rays against a disk in the y = 0 plane
		set_disk(0, 0, 0, 0, ONE, 0, 8 * ONE, 66);
		send_ray(ONE, 10 * ONE, -ONE, 0, -ONE, 0);
		send_ray(ONE, 10 * ONE, -ONE, ONE, 0, ONE);
		send_ray(ONE, 10 * ONE, -ONE, 0, 0, 0);
		send_ray(ONE, 10 * ONE, -ONE, 0, ONE, 0);
		send_ray(0, 66, 0, 0, -ONE, 0);
		send_ray(0, 67, 0, 0, -ONE, 0);
		send_ray(0, 2147483647, 0, 0, -1, 0);
		send_ray(0, -2147483648, 0, 0, 1, 0);
		send_ray(-2147483648, -2147483648, -2147483648, 2147483647, 2147483647, 2147483647);
		send_ray(2147483647, 2147483647, 2147483647, -2147483648, -2147483648, -2147483648);
		send_ray(9 * ONE, ONE, 0, 0, -ONE, 0);
		send_ray(2147483647, ONE, 0, 2147483647, -ONE, 0);
		send_ray(3 * ONE, 4 * ONE, 0, -ONE, -ONE, 0);
		send_ray(0, 0, 0, 0, -ONE, 0);
		send_ray(5 * ONE, ONE, 5 * ONE, 0, -ONE, 0);
		send_ray(-ONE, -3 * ONE, 2 * ONE, 0, ONE, 0);

		// Hit point beyond the signed range must saturate
		set_disk(2147483647 - 4 * ONE, 0, 0, 0, ONE, 0, 2147483647, 0);
		send_ray(2147483647, ONE, 0, 2 * ONE, -ONE, 0);
		send_ray(2147483647 - ONE, ONE, 0, ONE, -ONE, 0);

		set_disk(3 * ONE / 2, -2 * ONE, 3 * ONE, 0, 0, ONE, 4 * ONE, 0);
		random_phase(280, 0, 0, 1'b0);

		set_disk(rnd_span(ONE * 16), rnd_span(ONE * 16), rnd_span(ONE * 16),
			-ONE, 0, 0, 2 * ONE, ONE);
		random_phase(280, 84, 0, 1'b0);

		set_disk(2147418112, -2147418112, 0, 46341, 0, 46341, 2147483647, 0);
		random_phase(280, 0, 84, 1'b0);

		set_disk(rnd32(), rnd32(), rnd32(), rnd_normal(), rnd_normal(), rnd_normal(),
			$urandom_range(1, 1 << 22), $urandom_range(0, 1 << 12));
		random_phase(280, 9, 9, 1'b0);

		set_disk(-2147483648, 2147483647, 0, 0, -ONE, 0, 3 * ONE, 2147483647);
		random_phase(280, 0, 0, 1'b0);

		set_disk(rnd_span(ONE * 1000), rnd_span(ONE * 1000), rnd_span(ONE * 1000),
			0, 0, -ONE, $urandom_range(ONE, 32 * ONE), $urandom_range(0, ONE));
		random_phase(280, 9, 9, 1'b1);

		// Drain and give the verdict
		ray.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (fails == 0)
			$display("ray_disk_intersect test passed");
		else
			$display("ray_disk_intersect test failed");
		$finish;
	end

endmodule

// File: sim.f
rtl/rdi_pkg.sv
rtl/rdi_if.sv
rtl/rdi_front.sv
rtl/rdi_queue.sv
rtl/rdi_back.sv
rtl/ray_disk_intersect.sv
test/ray_disk_intersect_chk.sv
test/ray_disk_intersect_tb.sv
